/* hdl/assert_macros.svh */
// assertion macros shared by the checker files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define CHK_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked from the next clock edge
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/tsg_pkg.sv */
// package for the trapezoid step generator: widths, codes and constants
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package tsg_pkg;
   localparam logic [31:0] CLOCK_HZ = 32'd48000000;
   localparam logic [31:0] TICK_NUMERATOR = CLOCK_HZ * 32'd60;
   localparam logic [31:0] RESET_PERIOD = TICK_NUMERATOR / 32'd800;
   localparam logic [31:0] RESET_ACCEL_TICK = 32'd960000;
   localparam logic [23:0] RESET_MIN_RATE = 24'd800;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_START = 2'd1,
      OP_STOP  = 2'd2,
      OP_SETPOS = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_RUN  = 2'd1,
      MODE_SYNC = 2'd2
   } mode_type;

   // register byte addresses
   localparam logic [2:0] ADDR_ACCEL_TICK = 3'd0;
   localparam logic [2:0] ADDR_MIN_RATE   = 3'd4;

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_BRES,
      SEQ_BRES_SUB,
      SEQ_RATE,
      SEQ_ACC_ADD,
      SEQ_ACC_CMP,
      SEQ_NEW_RATE,
      SEQ_CLAMP,
      SEQ_DIV_START,
      SEQ_DIV_WAIT,
      SEQ_DONE
   } seq_type;

   // divider handshake
   typedef struct packed {
      logic        start;
      logic [24:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;
endpackage
`default_nettype wire

/* hdl/tsg_divider.sv */
// restoring divider: TICK_NUMERATOR over a 25-bit divisor, one bit a cycle
// depends on tsg_pkg
`timescale 1ns / 1ps
`default_nettype none
module tsg_divider import tsg_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);
   logic [31:0] quot_ff, quot_in;
   logic [25:0] rem_ff, rem_in;
   logic [24:0] dsr_ff, dsr_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [25:0] trial;
   logic [26:0] diff;

   // one quotient bit per cycle, numerator bits shifted in from the top
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      diff    = '0;
      if (div_req.start) begin
         quot_in = '0;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
         cnt_in  = 6'd31;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff[24:0], TICK_NUMERATOR[cnt_ff[4:0]]};
         diff  = {1'b0, trial} - {2'b00, dsr_ff};
         if (!diff[26]) begin
            rem_in  = diff[25:0];
            quot_in = {quot_ff[30:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      cnt_ff  <= cnt_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;
endmodule
`default_nettype wire

/* hdl/trapezoid_step_generator_unit.sv */
// top level of the trapezoid step generator: csr port, sequencer, state
// depends on tsg_pkg and tsg_divider
`timescale 1ns / 1ps
`default_nettype none
// One item is taken at a time. The sequencer states that each item passes are listed
// below, in order; every item ends in DONE.
// - Stop items, set-position items, and ticks while idle or awaiting sync go to DONE.
// - A start item always recomputes the period through CLAMP and the divider.
// - A running tick that ends the block or leaves the rate alone passes BRES, BRES_SUB, RATE.
// - A running tick also passes ACC_ADD and ACC_CMP when the accumulator does not fire.
// - A tick that snaps the rate to nominal goes from RATE through CLAMP and the divider.
// - A tick that steps the rate up or down adds NEW_RATE, CLAMP and the divider after ACC_CMP.
// These paths use the shared 34-bit adder of the sequencer and the shared restoring
// divider, which makes one quotient bit per cycle. A result is held in an output register
// until it is taken, and a result stall holds the next item back. req_stall is high while
// an item is in work or a result waits.
module trapezoid_step_generator_unit import tsg_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_operation,
   input  wire logic signed [31:0] req_move_length,
   input  wire logic [30:0]        req_event_total,
   input  wire logic [30:0]        req_accel_end,
   input  wire logic [30:0]        req_decel_start,
   input  wire logic [23:0]        req_initial_rate,
   input  wire logic [23:0]        req_nominal_rate,
   input  wire logic [23:0]        req_final_rate,
   input  wire logic [23:0]        req_rate_delta,
   input  wire logic signed [31:0] req_new_position,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_step_out,
   output logic                    rsp_dir_out,
   output logic [31:0]             rsp_tick_period,
   output logic [1:0]              rsp_run_status,
   output logic signed [31:0]      rsp_position_now,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [2:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);
   // configuration registers
   logic [31:0] accel_tick_ff;
   logic [23:0] min_rate_ff;
   logic        csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_tick_ff <= RESET_ACCEL_TICK;
         min_rate_ff   <= RESET_MIN_RATE;
      end else if (csr_write) begin
         unique case (paddr)
            ADDR_ACCEL_TICK: accel_tick_ff <= pwdata;
            ADDR_MIN_RATE:   min_rate_ff   <= pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr)
         ADDR_ACCEL_TICK: prdata = accel_tick_ff;
         ADDR_MIN_RATE:   prdata = {8'd0, min_rate_ff};
         default:         prdata = '0;
      endcase
   end

   // block store, written only by start items
   logic [31:0] blk_len_ff;
   logic [30:0] blk_total_ff, blk_aend_ff, blk_dstart_ff;
   logic [23:0] blk_nom_ff, blk_fin_ff, blk_delta_ff;

   // axis state
   seq_type     seq_ff, seq_in;
   mode_type    mode_ff, mode_in;
   logic [33:0] bres_ff, bres_in;
   logic [30:0] events_ff, events_in;
   logic [31:0] pos_ff, pos_in;
   logic [23:0] rate_ff, rate_in;
   logic [32:0] accum_ff, accum_in;
   logic [31:0] period_ff, period_in;
   logic [24:0] safe_ff, safe_in;
   logic        step_ff, step_in, dir_ff, dir_in;
   logic        out_valid_ff, out_valid_in;
   logic [24:0] cand_ff, cand_in;
   logic        load_blk;
   logic        accept, rsp_take;

   // shared adder
   logic [33:0] add_a, add_b, add_sum;
   logic        add_sub;
   assign add_sum = add_sub ? (add_a - add_b) : (add_a + add_b);

   div_req_type div_req;
   div_rsp_type div_rsp;

   tsg_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_stall = (seq_ff != SEQ_IDLE) || out_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign rsp_take  = out_valid_ff && !rsp_stall;

   // sequencer
   always_comb begin
      seq_in       = seq_ff;
      mode_in      = mode_ff;
      bres_in      = bres_ff;
      events_in    = events_ff;
      pos_in       = pos_ff;
      rate_in      = rate_ff;
      accum_in     = accum_ff;
      period_in    = period_ff;
      safe_in      = safe_ff;
      step_in      = step_ff;
      dir_in       = dir_ff;
      cand_in      = cand_ff;
      out_valid_in = out_valid_ff && !rsp_take;
      load_blk     = 1'b0;
      add_a        = '0;
      add_b        = '0;
      add_sub      = 1'b0;
      div_req.start   = 1'b0;
      div_req.divisor = '0;
      unique case (seq_ff)
         SEQ_IDLE: begin
            if (accept) begin
               step_in = 1'b0;
               dir_in  = 1'b0;
               unique case (op_type'(req_operation))
                  OP_START: begin
                     load_blk  = 1'b1;
                     mode_in   = MODE_RUN;
                     rate_in   = req_initial_rate;
                     accum_in  = {2'b00, accel_tick_ff[31:1]};
                     safe_in   = 25'(({2'b00, req_rate_delta} +
                                      {1'b0, req_rate_delta, 1'b0}) >> 1);
                     bres_in   = 34'd0 - {4'd0, req_event_total[30:1]};
                     events_in = '0;
                     seq_in    = SEQ_CLAMP;
                  end
                  OP_STOP: begin
                     mode_in = MODE_IDLE;
                     seq_in  = SEQ_DONE;
                  end
                  OP_SETPOS: begin
                     pos_in = req_new_position;
                     seq_in = SEQ_DONE;
                  end
                  default: begin
                     seq_in = (mode_ff == MODE_RUN) ? SEQ_BRES : SEQ_DONE;
                  end
               endcase
            end
         end
         SEQ_BRES: begin
            // error plus magnitude of the length
            dir_in  = blk_len_ff[31];
            add_a   = bres_ff;
            add_b   = blk_len_ff[31] ? (34'h1_0000_0000 - {2'b00, blk_len_ff})
                                     : {2'b00, blk_len_ff};
            bres_in = add_sum;
            seq_in  = SEQ_BRES_SUB;
         end
         SEQ_BRES_SUB: begin
            if (bres_ff != '0 && !bres_ff[33]) begin
               step_in = 1'b1;
               add_a   = bres_ff;
               add_b   = {3'd0, blk_total_ff};
               add_sub = 1'b1;
               bres_in = add_sum;
               pos_in  = dir_ff ? pos_ff - 32'd1 : pos_ff + 32'd1;
            end
            events_in = events_ff + 31'd1;
            seq_in    = SEQ_RATE;
         end
         SEQ_RATE: begin
            seq_in = SEQ_DONE;
            if (blk_total_ff <= events_ff) begin
               mode_in = MODE_SYNC;
            end else if (events_ff < blk_aend_ff) begin
               seq_in = SEQ_ACC_ADD;
            end else if (events_ff >= blk_dstart_ff) begin
               if (events_ff == blk_dstart_ff) begin
                  if (rate_ff == blk_nom_ff) begin
                     accum_in = {2'b00, accel_tick_ff[31:1]};
                  end else begin
                     add_a    = {2'b00, accel_tick_ff};
                     add_b    = {1'b0, accum_ff};
                     add_sub  = 1'b1;
                     accum_in = add_sum[32:0];
                  end
               end else begin
                  seq_in = SEQ_ACC_ADD;
               end
            end else if (rate_ff != blk_nom_ff) begin
               rate_in = blk_nom_ff;
               seq_in  = SEQ_CLAMP;
            end
         end
         SEQ_ACC_ADD: begin
            add_a    = {1'b0, accum_ff};
            add_b    = {2'b00, period_ff};
            accum_in = add_sum[32:0];
            seq_in   = SEQ_ACC_CMP;
         end
         SEQ_ACC_CMP: begin
            seq_in = SEQ_DONE;
            if (accum_ff > {1'b0, accel_tick_ff}) begin
               add_a    = {1'b0, accum_ff};
               add_b    = {2'b00, accel_tick_ff};
               add_sub  = 1'b1;
               accum_in = add_sum[32:0];
               seq_in   = SEQ_NEW_RATE;
            end
         end
         SEQ_NEW_RATE: begin
            // accelerate toward nominal or decelerate toward final
            if (events_ff < blk_aend_ff) begin
               add_a   = {10'd0, rate_ff};
               add_b   = {10'd0, blk_delta_ff};
               cand_in = add_sum[24:0];
               if (add_sum[24:0] >= {1'b0, blk_nom_ff}) begin
                  cand_in = {1'b0, blk_nom_ff};
               end
            end else begin
               if ({1'b0, rate_ff} > safe_ff) begin
                  add_a   = {10'd0, rate_ff};
                  add_b   = {10'd0, blk_delta_ff};
                  add_sub = 1'b1;
                  cand_in = add_sum[24:0];
                  if (add_sum[31:0] < {8'd0, blk_fin_ff}) begin
                     cand_in = {1'b0, blk_fin_ff};
                  end
               end else begin
                  cand_in = {2'b00, rate_ff[23:1]};
                  if (rate_ff[23:1] < blk_fin_ff) begin
                     cand_in = {1'b0, blk_fin_ff};
                  end
               end
            end
            seq_in = SEQ_CLAMP;
            // clamp stage below uses rate_ff, so load it here
            rate_in = cand_in[23:0];
         end
         SEQ_CLAMP: begin
            div_req.start = 1'b1;
            if (rate_ff < min_rate_ff) begin
               div_req.divisor = {1'b0, min_rate_ff};
            end else begin
               div_req.divisor = {1'b0, rate_ff};
            end
            if (div_req.divisor == '0) begin
               div_req.divisor = 25'd1;
            end
            seq_in = SEQ_DIV_START;
         end
         SEQ_DIV_START: begin
            seq_in = SEQ_DIV_WAIT;
         end
         SEQ_DIV_WAIT: begin
            if (div_rsp.done) begin
               period_in = div_rsp.quotient;
               seq_in    = SEQ_DONE;
            end
         end
         SEQ_DONE: begin
            out_valid_in = 1'b1;
            seq_in       = SEQ_IDLE;
         end
         default: seq_in = SEQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SEQ_IDLE;
         mode_ff      <= MODE_IDLE;
         bres_ff      <= '0;
         events_ff    <= '0;
         pos_ff       <= '0;
         rate_ff      <= '0;
         accum_ff     <= '0;
         period_ff    <= RESET_PERIOD;
         safe_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         mode_ff      <= mode_in;
         bres_ff      <= bres_in;
         events_ff    <= events_in;
         pos_ff       <= pos_in;
         rate_ff      <= rate_in;
         accum_ff     <= accum_in;
         period_ff    <= period_in;
         safe_ff      <= safe_in;
         out_valid_ff <= out_valid_in;
      end
      step_ff <= step_in;
      dir_ff  <= dir_in;
      cand_ff <= cand_in;
      if (load_blk) begin
         blk_len_ff    <= req_move_length;
         blk_total_ff  <= req_event_total;
         blk_aend_ff   <= req_accel_end;
         blk_dstart_ff <= req_decel_start;
         blk_nom_ff    <= req_nominal_rate;
         blk_fin_ff    <= req_final_rate;
         blk_delta_ff  <= req_rate_delta;
      end
   end

   // result register
   assign rsp_valid        = out_valid_ff;
   assign rsp_step_out     = step_ff;
   assign rsp_dir_out      = dir_ff;
   assign rsp_tick_period  = period_ff;
   assign rsp_run_status   = mode_ff;
   assign rsp_position_now = pos_ff;
endmodule
`default_nettype wire

/* hdl/tsg_checker.sv */
// port-level checker for the trapezoid step generator, bound to the top
// depends on tsg_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tsg_checker import tsg_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_step_out,
   input wire logic        rsp_dir_out,
   input wire logic [1:0]  rsp_run_status,
   input wire logic [31:0] rsp_tick_period
);
   // no new transfer is taken while a result waits
   `CHK_ALWAYS(a_no_accept_while_held, clock, reset, !(rsp_valid && !req_stall), "accepting with result pending")
   // a transfer in leads to busy on the next edge
   `CHK_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "not busy after accept")
   // step or direction only come with a running or just-finished block
   `CHK_ALWAYS(a_step_mode, clock, reset, !(rsp_valid && (rsp_step_out || rsp_dir_out)) || rsp_run_status != MODE_IDLE, "step while idle")
   // held result keeps its period
   `CHK_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, $stable(rsp_tick_period), "result changed while stalled")
endmodule
bind trapezoid_step_generator_unit tsg_checker u_tsg_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_step_out    (rsp_step_out),
   .rsp_dir_out     (rsp_dir_out),
   .rsp_run_status  (rsp_run_status),
   .rsp_tick_period (rsp_tick_period)
);
`default_nettype wire

/* tb/sv/tb_trapezoid_step_generator_unit.sv */
// testbench for the trapezoid step generator: random and directed items, checked by a predictor
// depends on tsg_pkg and trapezoid_step_generator_unit
`timescale 1ns / 1ps
module tb_trapezoid_step_generator_unit;
   import tsg_pkg::*;

   typedef struct {
      op_type             op;
      logic signed [31:0] len;
      logic [30:0]        total;
      logic [30:0]        aend;
      logic [30:0]        dstart;
      logic [23:0]        rinit;
      logic [23:0]        rnom;
      logic [23:0]        rfin;
      logic [23:0]        rdelta;
      logic signed [31:0] pos;
   } move_item;

   typedef struct packed {
      logic        step;
      logic        dir;
      logic [31:0] period;
      logic [1:0]  status;
      logic [31:0] position;
   } step_status;

   // stepper predictor and queue of expected step results
   class step_scoreboard;
      logic [31:0] cpat;
      logic [23:0] min_rate;
      mode_type    mode;
      logic [33:0] bres;
      logic [30:0] done;
      logic [31:0] position;
      logic [23:0] rate;
      logic [32:0] accum;
      logic [31:0] period;
      logic [24:0] safe;
      move_item    blk;
      step_status  pending[$];
      int          errors;

      function void reset_state();
         cpat = RESET_ACCEL_TICK;
         min_rate = RESET_MIN_RATE;
         mode = MODE_IDLE;
         bres = '0;
         done = '0;
         position = '0;
         rate = '0;
         accum = '0;
         safe = '0;
         recompute_period();
      endfunction

      function void recompute_period();
         logic [31:0] r;
         r = {8'd0, rate};
         if (r < {8'd0, min_rate}) r = {8'd0, min_rate};
         if (r == 0) r = 1;
         period = TICK_NUMERATOR / r;
      endfunction

      function bit accum_fires();
         accum = accum + {1'b0, period};
         if (accum > {1'b0, cpat}) begin
            accum = accum - {1'b0, cpat};
            return 1;
         end
         return 0;
      endfunction

      // accelerate, cruise or decelerate after a tick
      function void shape_rate();
         logic [31:0] r;
         if (done < blk.aend) begin
            if (accum_fires()) begin
               r = {8'd0, rate} + {8'd0, blk.rdelta};
               if (r >= {8'd0, blk.rnom}) r = {8'd0, blk.rnom};
               rate = r[23:0];
               recompute_period();
            end
         end else if (done >= blk.dstart) begin
            if (done == blk.dstart) begin
               if (rate == blk.rnom) accum = {1'b0, cpat >> 1};
               else accum = {1'b0, cpat} - accum;
            end else if (accum_fires()) begin
               r = {8'd0, rate};
               if (r > {7'd0, safe}) r = r - {8'd0, blk.rdelta};
               else r = r >> 1;
               if (r < {8'd0, blk.rfin}) r = {8'd0, blk.rfin};
               rate = r[23:0];
               recompute_period();
            end
         end else if (rate != blk.rnom) begin
            rate = blk.rnom;
            recompute_period();
         end
      endfunction

      function void note_input(move_item it);
         logic [32:0] mag;
         step_status  e;
         e.step = 0;
         e.dir = 0;
         case (it.op)
            OP_START: begin
               blk = it;
               mode = MODE_RUN;
               rate = it.rinit;
               recompute_period();
               accum = {1'b0, cpat >> 1};
               safe = 25'(({8'd0, it.rdelta} * 32'd3) >> 1);
               bres = 34'd0 - {3'd0, it.total >> 1};
               done = '0;
            end
            OP_STOP: mode = MODE_IDLE;
            OP_SETPOS: position = it.pos;
            default: begin
               if (mode == MODE_RUN) begin
                  e.dir = blk.len[31];
                  mag = e.dir ? 33'h100000000 - {1'b0, blk.len} : {1'b0, blk.len};
                  bres = bres + {1'b0, mag};
                  if (bres != 0 && !bres[33]) begin
                     e.step = 1;
                     bres = bres - {3'd0, blk.total};
                     position = position + (e.dir ? 32'hFFFFFFFF : 32'd1);
                  end
                  done = done + 31'd1;
                  if (blk.total <= done) mode = MODE_SYNC;
                  else shape_rate();
               end
            end
         endcase
         e.period = period;
         e.status = mode;
         e.position = position;
         pending.push_back(e);
      endfunction

      function void check_result(step_status got);
         step_status e;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result transfer at %0t", $realtime);
            return;
         end
         e = pending.pop_front();
         if (got != e) begin
            errors++;
            if (errors <= 10)
               $display("mismatch at %0t: exp step %0d dir %0d period %0d status %0d pos %0d, got step %0d dir %0d period %0d status %0d pos %0d",
                  $realtime, e.step, e.dir, e.period, e.status, $signed(e.position),
                  got.step, got.dir, got.period, got.status, $signed(got.position));
         end
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic [1:0]         req_operation = '0;
   logic signed [31:0] req_move_length = '0;
   logic [30:0]        req_event_total = '0;
   logic [30:0]        req_accel_end = '0;
   logic [30:0]        req_decel_start = '0;
   logic [23:0]        req_initial_rate = '0;
   logic [23:0]        req_nominal_rate = '0;
   logic [23:0]        req_final_rate = '0;
   logic [23:0]        req_rate_delta = '0;
   logic signed [31:0] req_new_position = '0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic               rsp_step_out;
   logic               rsp_dir_out;
   logic [31:0]        rsp_tick_period;
   logic [1:0]         rsp_run_status;
   logic signed [31:0] rsp_position_now;
   logic               psel = 0;
   logic               penable = 0;
   logic               pwrite = 0;
   logic [2:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   step_scoreboard sb;
   bit             steady = 0;
   int             sent = 0;

   trapezoid_step_generator_unit dut (.*);

   always #2 clock = ~clock;

   // result side stalls at random except in steady stretches
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall && !reset)
         sb.check_result('{rsp_step_out, rsp_dir_out, rsp_tick_period, rsp_run_status,
                           rsp_position_now});
      rsp_stall <= !steady && ($urandom_range(99) < 11);
   end

   // one input transfer, with a random gap in front
   task automatic send_move(move_item it);
      while (!steady && $urandom_range(99) < 11) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_operation <= it.op;
      req_move_length <= it.len;
      req_event_total <= it.total;
      req_accel_end <= it.aend;
      req_decel_start <= it.dstart;
      req_initial_rate <= it.rinit;
      req_nominal_rate <= it.rnom;
      req_final_rate <= it.rfin;
      req_rate_delta <= it.rdelta;
      req_new_position <= it.pos;
      do @(posedge clock); while (req_stall);
      sb.note_input(it);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   // register write, only with the block drained
   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      drain();
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      if (addr == ADDR_ACCEL_TICK) sb.cpat = data;
      else sb.min_rate = data[23:0];
   endtask

   function automatic move_item blank(op_type op);
      move_item it;
      it = '{op, 32'sd0, 31'd0, 31'd0, 31'd0, 24'd0, 24'd0, 24'd0, 24'd0, 32'sd0};
      return it;
   endfunction

   function automatic move_item noise_item();
      move_item it;
      it = '{op_type'($urandom_range(3)), $urandom, 31'($urandom), 31'($urandom),
             31'($urandom), 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
             $urandom};
      return it;
   endfunction

   function automatic move_item start_item(logic [30:0] total, logic signed [31:0] len,
                                           logic [23:0] rinit, logic [23:0] rnom,
                                           logic [23:0] rfin, logic [23:0] rdelta);
      move_item it;
      it = blank(OP_START);
      it.total = total;
      it.len = len;
      it.aend = 31'(total / 31'd3);
      it.dstart = 31'(total - total / 31'd3);
      it.rinit = rinit;
      it.rnom = rnom;
      it.rfin = rfin;
      it.rdelta = rdelta;
      return it;
   endfunction

   function automatic logic [23:0] rand_rate();
      case ($urandom_range(3))
         0: return 24'($urandom_range(2000));
         1: return 24'($urandom);
         default: return 24'($urandom_range(200000));
      endcase
   endfunction

   // a well-formed block with ticks past its end, now and then broken up
   task automatic run_block();
      move_item    it;
      logic [30:0] total;
      int          ticks;
      if ($urandom_range(19) == 0) total = 31'($urandom);
      else total = 31'($urandom_range(40));
      it = start_item(total, 32'sd0, rand_rate(), rand_rate(), rand_rate(), rand_rate());
      if ($urandom_range(9) == 0) it.len = $urandom;
      else it.len = $signed(32'($urandom_range(2 * total))) * ($urandom_range(1) ? 1 : -1);
      if ($urandom_range(4) == 0) it.aend = 31'($urandom);
      else it.aend = 31'($urandom_range(total));
      if ($urandom_range(4) == 0) it.dstart = 31'($urandom);
      else it.dstart = 31'($urandom_range(total));
      send_move(it);
      ticks = (total > 60 ? 60 : int'(total)) + $urandom_range(2);
      repeat (ticks) begin
         if ($urandom_range(19) == 0) send_move(noise_item());
         else send_move(blank(OP_TICK));
      end
   endtask

   task automatic random_part(int count);
      int goal;
      goal = sent + count;
      while (sent < goal) begin
         if ($urandom_range(99) < 85) run_block();
         else send_move(noise_item());
      end
   endtask

   initial begin
      move_item it;
      sb = new();
      sb.reset_state();
      sb.errors = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: idle tick, position extremes, direction extremes, end of block
      send_move(blank(OP_TICK));
      it = blank(OP_SETPOS);
      it.pos = 32'sh7FFFFFFF;
      send_move(it);
      send_move(blank(OP_TICK));
      it = blank(OP_SETPOS);
      it.pos = 32'sh80000000;
      send_move(it);
      send_move(start_item(31'd6, 32'sh80000000, 24'd0, 24'hFFFFFF, 24'd0, 24'hFFFFFF));
      repeat (4) send_move(blank(OP_TICK));
      send_move(blank(OP_STOP));
      send_move(blank(OP_TICK));
      send_move(start_item(31'd0, 32'sd5, 24'd1000, 24'd2000, 24'd500, 24'd100));
      send_move(blank(OP_TICK));
      send_move(blank(OP_TICK));
      send_move(start_item(31'h7FFFFFFF, 32'sh7FFFFFFF, 24'hFFFFFF, 24'd1, 24'hFFFFFF,
                           24'd0));
      repeat (3) send_move(blank(OP_TICK));
      send_move(start_item(31'd5, -32'sd5, 24'd800, 24'd800, 24'd800, 24'd10));
      repeat (6) send_move(blank(OP_TICK));

      random_part(250);
      csr_write(ADDR_ACCEL_TICK, 32'd1);
      csr_write(ADDR_MIN_RATE, 32'hFFFFFF);
      steady = 1;
      random_part(150);
      steady = 0;
      csr_write(ADDR_ACCEL_TICK, 32'hFFFFFFFF);
      csr_write(ADDR_MIN_RATE, 32'd1);
      random_part(200);
      csr_write(ADDR_ACCEL_TICK, 32'd0);
      csr_write(ADDR_MIN_RATE, 32'd0);
      random_part(150);
      csr_write(ADDR_ACCEL_TICK, 32'd3000);
      csr_write(ADDR_MIN_RATE, 32'd800);
      random_part(175);

      drain();
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("[trapezoid_step_generator_unit] OK");
      end else begin
         $display("[trapezoid_step_generator_unit] ERROR");
      end
      $finish;
   end

   // hard limit on run time
   initial begin
      #20ms;
      $display("[trapezoid_step_generator_unit] ERROR");
      $finish;
   end
endmodule
